>>> rtl/bmrr_pkg.sv
// Shared constants, register indexes and config type for the bitmap row-repeat decoder.
// No dependencies; used by bmrr_front, bmrr_back and bitmap_row_repeat_decoder under rtl/.
package bmrr_pkg;

    // fixed field widths
    localparam int DATA_W     = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 10;
    localparam int NB_W       = 8;   // groups per row, up to 128 from a 10-bit width
    localparam int CNT_W      = 4;
    localparam int OUT_W      = 16;  // bits, count, row_end, frame_end, padded

    localparam logic [CNT_W-1:0] PIX_FULL = 4'd8;

    // defaults for the top-level parameters
    localparam int SLOT_COUNT_DEF     = 16;
    localparam int BLACK_SLOT_DEF     = 8;
    localparam int MAX_ROW_PIXELS_DEF = 512;
    localparam int FIFO_DEPTH         = 4;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_ROW_WIDTH    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW_TOTAL    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ESC_MASK     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ESC_VALUE    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_COMPRESS_ON  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_ONE_IS_WHITE = 3'd5;

    // register reset values
    localparam logic [9:0] RST_ROW_WIDTH = 10'd8;
    localparam logic [9:0] RST_ROW_TOTAL = 10'd1;
    localparam logic [7:0] RST_ESC_MASK  = 8'hF0;
    localparam logic [7:0] RST_ESC_VALUE = 8'hF0;

    typedef struct packed {
        logic [9:0] row_width;
        logic [9:0] row_total;
        logic [7:0] escape_mask;
        logic [7:0] escape_value;
        logic       compression_on;
    } t_cfg;

    // bits of the row-byte index for a given maximum row width
    function automatic int f_byte_w(input int max_px);
        int rb;
        rb = (max_px + 7) >> 3;
        return (rb > 1) ? $clog2(rb) : 1;
    endfunction

    // width of the packed front-to-back command word (layout in bmrr_front/bmrr_back)
    function automatic int f_cmd_w(input int sw, input int bw);
        return 25 + 2 * sw + bw;
    endfunction

endpackage

>>> rtl/bmrr_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module bmrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/bmrr_fifo.sv
// Small flop-based command queue between the front and back of the decoder.
// No package dependencies.
module bmrr_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_q [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_cnt, n_cnt;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_comb begin
        n_wptr = i_push ? f_inc(r_wptr) : r_wptr;
        n_rptr = i_pop ? f_inc(r_rptr) : r_rptr;
        n_cnt  = r_cnt + CW'(i_push) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wptr] <= i_data;
        end
    end

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_q[r_rptr];
endmodule

>>> rtl/bmrr_front.sv
// Front end: takes stream bytes, tracks row/frame/slot bookkeeping, classifies
// literal vs escape and pushes one command per byte. Depends on bmrr_pkg.
module bmrr_front #(
    parameter int SLOT_COUNT     = bmrr_pkg::SLOT_COUNT_DEF,
    parameter int BLACK_SLOT     = bmrr_pkg::BLACK_SLOT_DEF,
    parameter int MAX_ROW_PIXELS = bmrr_pkg::MAX_ROW_PIXELS_DEF,
    parameter int CMD_W          = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bmrr_pkg::t_cfg              i_cfg,
    input  logic                        i_tvalid,
    output logic                        o_tready,
    input  logic [bmrr_pkg::DATA_W-1:0] i_tdata,
    input  logic                        i_full,
    output logic                        o_push,
    output logic [CMD_W-1:0]            o_cmd
);
    import bmrr_pkg::*;

    localparam int SW   = $clog2(SLOT_COUNT);
    localparam int BW   = f_byte_w(MAX_ROW_PIXELS);
    localparam int RW   = $clog2(BLACK_SLOT);
    localparam int IW   = $clog2(SLOT_COUNT + BLACK_SLOT + 2);
    localparam int WCAP = (MAX_ROW_PIXELS > 1023) ? 1023 : MAX_ROW_PIXELS;

    typedef struct packed {
        logic              lit;
        logic [7:0]        data;
        logic [SW-1:0]     slot_a;    // recent slot (literal) or replay slot (escape)
        logic [SW-1:0]     slot_b;    // initial slot
        logic              wr_b;
        logic [BW-1:0]     idx;
        logic [CNT_W-1:0]  last_cnt;
        logic [NB_W-1:0]   nb;
        logic              filled;
        logic              fe;
        logic              row_last;
    } t_cmd;

    // byte mod SLOT_COUNT lookup
    logic [SW-1:0] w_mod_tab [256];
    for (genvar g = 0; g < 256; g++) begin : g_mod
        assign w_mod_tab[g] = SW'(g % SLOT_COUNT);
    end

    logic                  r_in_lit, n_in_lit;
    logic [BW-1:0]         r_byte, n_byte;
    logic [9:0]            r_rows, n_rows;
    logic [RW-1:0]         r_recent, n_recent;
    logic [IW-1:0]         r_init, n_init;
    logic [SLOT_COUNT-1:0] r_filled, n_filled;

    logic [9:0]       w_width, w_width_m1, w_total;
    logic [10:0]      w_width_p7;
    logic [NB_W-1:0]  w_nb;
    logic [CNT_W-1:0] w_last_cnt;
    logic             w_fe, w_esc, w_row_last, w_wr_b;
    logic [SW-1:0]    w_slot_esc, w_slot_rec, w_slot_init;
    t_cmd             w_cmd;

    always_comb begin
        w_width = (i_cfg.row_width == '0) ? 10'd1 : i_cfg.row_width;
        if (w_width > 10'(WCAP)) begin
            w_width = 10'(WCAP);
        end
        w_width_p7 = {1'b0, w_width} + 11'd7;
        w_nb       = w_width_p7[10:3];
        w_width_m1 = w_width - 10'd1;
        w_last_cnt = {1'b0, w_width_m1[2:0]} + CNT_W'(1);
        w_total    = (i_cfg.row_total == '0) ? 10'd1 : i_cfg.row_total;
        w_fe       = ({1'b0, r_rows} + 11'd1) >= {1'b0, w_total};

        w_esc = !r_in_lit && i_cfg.compression_on &&
                ((i_tdata & i_cfg.escape_mask) == i_cfg.escape_value);
        w_row_last  = ({{(NB_W + 1 - BW){1'b0}}, r_byte} + (NB_W + 1)'(1)) >= {1'b0, w_nb};
        w_slot_esc  = w_mod_tab[i_tdata];
        w_slot_rec  = w_mod_tab[8'(r_recent)];
        w_wr_b      = r_init < IW'(SLOT_COUNT);
        w_slot_init = SW'(r_init);

        w_cmd.lit      = !w_esc;
        w_cmd.data     = i_tdata;
        w_cmd.slot_a   = w_esc ? w_slot_esc : w_slot_rec;
        w_cmd.slot_b   = w_slot_init;
        w_cmd.wr_b     = w_wr_b;
        w_cmd.idx      = r_byte;
        w_cmd.last_cnt = w_last_cnt;
        w_cmd.nb       = w_nb;
        w_cmd.filled   = r_filled[w_slot_esc];
        w_cmd.fe       = w_fe;
        w_cmd.row_last = w_row_last;
    end

    assign o_tready = !i_full;
    assign o_push   = i_tvalid && !i_full;
    assign o_cmd    = CMD_W'(w_cmd);

    always_comb begin
        n_in_lit = r_in_lit;
        n_byte   = r_byte;
        n_rows   = r_rows;
        n_recent = r_recent;
        n_init   = r_init;
        n_filled = r_filled;
        if (o_push) begin
            if (!w_esc && !w_row_last) begin
                n_in_lit = 1'b1;
                n_byte   = r_byte + BW'(1);
            end else begin
                if (!w_esc) begin
                    n_filled[w_slot_rec] = 1'b1;
                    if (w_wr_b) begin
                        n_filled[w_slot_init] = 1'b1;
                        n_init = r_init + IW'(1);
                    end
                    n_recent = (r_recent == RW'(BLACK_SLOT - 1)) ? '0 : r_recent + RW'(1);
                    n_in_lit = 1'b0;
                    n_byte   = '0;
                end
                // row finished
                if (w_fe) begin
                    n_rows   = '0;
                    n_filled = '0;
                    n_recent = '0;
                    n_init   = IW'(BLACK_SLOT + 1);
                end else begin
                    n_rows = r_rows + 10'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_lit <= 1'b0;
            r_byte   <= '0;
            r_rows   <= '0;
            r_recent <= '0;
            r_init   <= IW'(BLACK_SLOT + 1);
            r_filled <= '0;
        end else begin
            r_in_lit <= n_in_lit;
            r_byte   <= n_byte;
            r_rows   <= n_rows;
            r_recent <= n_recent;
            r_init   <= n_init;
            r_filled <= n_filled;
        end
    end
endmodule

>>> rtl/bmrr_back.sv
// Back end: executes queued commands against the row store, replays stored rows
// and drives the registered output word. Depends on bmrr_pkg and bmrr_ram.
module bmrr_back #(
    parameter int SLOT_COUNT     = bmrr_pkg::SLOT_COUNT_DEF,
    parameter int MAX_ROW_PIXELS = bmrr_pkg::MAX_ROW_PIXELS_DEF,
    parameter int CMD_W          = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_one_is_white,
    input  logic                       i_cmd_valid,
    input  logic [CMD_W-1:0]           i_cmd,
    output logic                       o_pop,
    output logic                       o_tvalid,
    input  logic                       i_tready,
    output logic [bmrr_pkg::OUT_W-1:0] o_tdata,
    output logic                       o_tlast
);
    import bmrr_pkg::*;

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int BW = f_byte_w(MAX_ROW_PIXELS);
    localparam int AW = SW + BW;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LIT_B = 2'd1;   // second write of a literal byte
    localparam logic [1:0] ST_ESC   = 2'd2;   // replay groups

    typedef struct packed {
        logic              lit;
        logic [7:0]        data;
        logic [SW-1:0]     slot_a;
        logic [SW-1:0]     slot_b;
        logic              wr_b;
        logic [BW-1:0]     idx;
        logic [CNT_W-1:0]  last_cnt;
        logic [NB_W-1:0]   nb;
        logic              filled;
        logic              fe;
        logic              row_last;
    } t_cmd;

    t_cmd            w_head;
    t_cmd            r_cmd, n_cmd;
    logic [1:0]      r_state, n_state;
    logic [NB_W-1:0] r_k, n_k;

    logic             r_out_valid;
    logic [7:0]       r_out_bits, n_out_bits;
    logic [CNT_W-1:0] r_out_cnt, n_out_cnt;
    logic             r_out_re, n_out_re;
    logic             r_out_fe, n_out_fe;
    logic             r_out_last, n_out_last;

    logic          w_free, w_load, w_k_last;
    logic          w_we, w_re;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [7:0]    w_wdata, w_rdata;
    logic [NB_W-1:0] w_k_next;

    assign w_head   = t_cmd'(i_cmd);
    assign w_free   = !r_out_valid || i_tready;
    assign w_k_next = r_k + NB_W'(1);
    assign w_k_last = (w_k_next == r_cmd.nb);

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_k        = r_k;
        o_pop      = 1'b0;
        w_load     = 1'b0;
        w_we       = 1'b0;
        w_re       = 1'b0;
        w_waddr    = {w_head.slot_a, w_head.idx};
        w_wdata    = w_head.data;
        w_raddr    = {w_head.slot_a, BW'(0)};
        n_out_bits = i_one_is_white ? w_head.data : ~w_head.data;
        n_out_cnt  = w_head.row_last ? w_head.last_cnt : PIX_FULL;
        n_out_re   = w_head.row_last;
        n_out_fe   = w_head.row_last && w_head.fe;
        n_out_last = 1'b1;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (w_head.lit) begin
                        if (w_free) begin
                            w_we    = 1'b1;
                            w_load  = 1'b1;
                            o_pop   = 1'b1;
                            n_cmd   = w_head;
                            n_state = w_head.wr_b ? ST_LIT_B : ST_IDLE;
                        end
                    end else begin
                        // first read goes out with the pop
                        w_re    = 1'b1;
                        o_pop   = 1'b1;
                        n_cmd   = w_head;
                        n_k     = '0;
                        n_state = ST_ESC;
                    end
                end
            end
            ST_LIT_B: begin
                w_we    = 1'b1;
                w_waddr = {r_cmd.slot_b, r_cmd.idx};
                w_wdata = r_cmd.data;
                n_state = ST_IDLE;
            end
            ST_ESC: begin
                w_raddr    = {r_cmd.slot_a, BW'(w_k_next)};
                n_out_bits = !r_cmd.filled ? 8'h00 :
                             (i_one_is_white ? w_rdata : ~w_rdata);
                n_out_cnt  = w_k_last ? r_cmd.last_cnt : PIX_FULL;
                n_out_re   = w_k_last;
                n_out_fe   = w_k_last && r_cmd.fe;
                n_out_last = w_k_last;
                if (w_free) begin
                    w_load = 1'b1;
                    if (w_k_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        w_re = 1'b1;
                        n_k  = w_k_next;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    bmrr_ram #(
        .WIDTH (8),
        .DEPTH (1 << AW)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_k   <= n_k;
        if (w_load) begin
            r_out_bits <= n_out_bits;
            r_out_cnt  <= n_out_cnt;
            r_out_re   <= n_out_re;
            r_out_fe   <= n_out_fe;
            r_out_last <= n_out_last;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = {2'b00, r_out_fe, r_out_re, r_out_cnt, r_out_bits};
    assign o_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_lit_b_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LIT_B |=> r_state == ST_IDLE)
        else $error("second literal write did not return to idle");

    a_k_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ESC |-> r_k < r_cmd.nb)
        else $error("replay index ran past row length");

    a_esc_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ESC && w_load && w_k_last) |=> (r_state == ST_IDLE && o_tlast))
        else $error("replay end not marked on output");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == ST_IDLE && i_cmd_valid))
        else $error("command popped outside idle or from empty queue");
`endif
endmodule

>>> rtl/bitmap_row_repeat_decoder.sv
// Bytes are queued as commands in a 4-entry FIFO that decouples s_axis from m_axis; the back end
// pops each into the output register, an escape via the row-store read register, one group
// per cycle while m_axis_tready is high. A literal also writing an initial slot needs a second
// write on the one RAM write port; an escape holds the back end until its nb groups are out.
// Reset: i_rst_n synchronous active low; registers, counters and slot flags return to
// their reset values. The row store is not cleared.
module bitmap_row_repeat_decoder #(
    parameter int SLOT_COUNT     = bmrr_pkg::SLOT_COUNT_DEF,
    parameter int BLACK_SLOT     = bmrr_pkg::BLACK_SLOT_DEF,
    parameter int MAX_ROW_PIXELS = bmrr_pkg::MAX_ROW_PIXELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bmrr_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [bmrr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [bmrr_pkg::DATA_W-1:0]     s_axis_tdata,  // [7:0] data_byte
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] white_bits, [11:8] pixel_count, [12] row_end, [13] frame_end, [15:14] zero
    output logic [bmrr_pkg::OUT_W-1:0]      m_axis_tdata,
    output logic                            m_axis_tlast   // run_last
);
    import bmrr_pkg::*;

    localparam int CMD_W = f_cmd_w($clog2(SLOT_COUNT), f_byte_w(MAX_ROW_PIXELS));

    t_cfg r_cfg;
    logic r_one_is_white;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_width      <= RST_ROW_WIDTH;
            r_cfg.row_total      <= RST_ROW_TOTAL;
            r_cfg.escape_mask    <= RST_ESC_MASK;
            r_cfg.escape_value   <= RST_ESC_VALUE;
            r_cfg.compression_on <= 1'b1;
            r_one_is_white       <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_ROW_WIDTH:    r_cfg.row_width      <= i_cfg_data;
                REG_ROW_TOTAL:    r_cfg.row_total      <= i_cfg_data;
                REG_ESC_MASK:     r_cfg.escape_mask    <= i_cfg_data[7:0];
                REG_ESC_VALUE:    r_cfg.escape_value   <= i_cfg_data[7:0];
                REG_COMPRESS_ON:  r_cfg.compression_on <= i_cfg_data[0];
                REG_ONE_IS_WHITE: r_one_is_white       <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    logic             w_push, w_pop, w_full, w_empty;
    logic [CMD_W-1:0] w_cmd_in, w_cmd_out;

    bmrr_front #(
        .SLOT_COUNT     (SLOT_COUNT),
        .BLACK_SLOT     (BLACK_SLOT),
        .MAX_ROW_PIXELS (MAX_ROW_PIXELS),
        .CMD_W          (CMD_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_cmd    (w_cmd_in)
    );

    bmrr_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_cmd_out),
        .o_empty (w_empty)
    );

    bmrr_back #(
        .SLOT_COUNT     (SLOT_COUNT),
        .MAX_ROW_PIXELS (MAX_ROW_PIXELS),
        .CMD_W          (CMD_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_one_is_white (r_one_is_white),
        .i_cmd_valid    (!w_empty),
        .i_cmd          (w_cmd_out),
        .o_pop          (w_pop),
        .o_tvalid       (m_axis_tvalid),
        .i_tready       (m_axis_tready),
        .o_tdata        (m_axis_tdata),
        .o_tlast        (m_axis_tlast)
    );
endmodule

>>> tb/sv/tb_bitmap_row_repeat_decoder.sv
`timescale 1ns / 1ps
// Self-checking bench for bitmap_row_repeat_decoder: a directed script, then random phases
// of literal rows, escapes and noise, every output word checked against an in-bench decoder.
// Depends on rtl/bmrr_pkg.sv and rtl/bitmap_row_repeat_decoder.sv.
module tb_bitmap_row_repeat_decoder;
    import bmrr_pkg::*;

    localparam int SLOTS       = SLOT_COUNT_DEF;
    localparam int BLACK       = BLACK_SLOT_DEF;
    localparam int MAX_PX      = MAX_ROW_PIXELS_DEF;
    localparam int ROW_B       = (MAX_PX + 7) / 8;
    localparam int IDLE_LIMIT  = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_PAUSE = 8;
    localparam int PHASES      = 8;

    // indexes past the register list, writes must be ignored
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [7:0] white_bits;
        logic [3:0] pixel_count;
        logic       row_end;
        logic       frame_end;
        logic       run_last;
    } t_pixel_group;

    typedef enum logic {STEP_BYTE, STEP_REG} t_step;

    typedef struct packed {
        t_step                  kind;
        logic [CFG_ADDR_W-1:0]  addr;
        logic [CFG_DATA_W-1:0]  value;
        logic                   typed;
        t_pixel_group           grp;
    } t_script_row;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [DATA_W-1:0]     s_axis_tdata  = '0;   // [7:0] data_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;         // [7:0] bits, [11:8] count, [12] row, [13] frame
    logic                  m_axis_tlast;

    always #5 i_clk = ~i_clk;

    bitmap_row_repeat_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // decoder mirror: registers and row state
    logic [9:0]       cfg_width = RST_ROW_WIDTH;
    logic [9:0]       cfg_total = RST_ROW_TOTAL;
    logic [7:0]       cfg_mask  = RST_ESC_MASK;
    logic [7:0]       cfg_value = RST_ESC_VALUE;
    logic             cfg_comp  = 1'b1;
    logic             cfg_white = 1'b1;
    logic [7:0]       row_mem    [SLOTS*ROW_B];
    bit               row_mem_ok [SLOTS*ROW_B];
    logic [SLOTS-1:0] slot_filled = '0;
    logic [2:0]       ring_next   = '0;
    logic [4:0]       init_next   = 5'(BLACK + 1);
    logic [6:0]       col         = '0;
    logic             in_lit      = 1'b0;
    logic [9:0]       rows_done   = '0;

    t_pixel_group pending_groups[$];
    t_script_row  script[$];
    int           err_cnt    = 0;
    int           burst_left = 0;

    logic         hold_req  = 1'b0;
    bit           hold_done = 1'b0;
    int           hold_left = 0;
    logic [7:0]   pace      = '0;
    int           idle_cycles = 0;

    function automatic void row_shape(output int nb, output logic [3:0] tail);
        int w;
        w = (cfg_width == 0) ? 1 : int'(cfg_width);
        if (w > MAX_PX) w = MAX_PX;
        nb   = (w + 7) / 8;
        tail = 4'(((w - 1) % 8) + 1);
    endfunction

    function automatic bit is_escape(input logic [7:0] b);
        return !in_lit && cfg_comp && ((b & cfg_mask) == cfg_value);
    endfunction

    // an escape must never replay a stored byte that was never written
    function automatic bit replay_defined(input logic [7:0] b);
        int nb, base, k;
        logic [3:0] tail;
        row_shape(nb, tail);
        base = (b % SLOTS) * ROW_B;
        if (!is_escape(b) || !slot_filled[b % SLOTS]) return 1'b1;
        for (k = 0; k < nb; k++)
            if (!row_mem_ok[base + k]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void close_row(input logic fe);
        rows_done = rows_done + 10'd1;
        if (fe) begin
            rows_done   = '0;
            slot_filled = '0;
            ring_next   = '0;
            init_next   = 5'(BLACK + 1);
        end
    endfunction

    // expected groups for one accepted data byte
    task automatic decode_byte(input logic [7:0] b);
        int nb, slot, k, idx;
        logic [3:0] tail;
        logic fe, last;
        logic [7:0] v;
        t_pixel_group g;
        row_shape(nb, tail);
        fe = (int'(rows_done) + 1 >= ((cfg_total == 0) ? 1 : int'(cfg_total)));
        if (is_escape(b)) begin
            slot = b % SLOTS;
            for (k = 0; k < nb; k++) begin
                last = (k == nb - 1);
                v = slot_filled[slot] ? row_mem[slot * ROW_B + k] : 8'h00;
                if (slot_filled[slot] && !cfg_white) v = ~v;
                g.white_bits  = v;
                g.pixel_count = last ? tail : PIX_FULL;
                g.row_end     = last;
                g.frame_end   = last & fe;
                g.run_last    = last;
                pending_groups.push_back(g);
            end
            close_row(fe);
        end else begin
            if (!in_lit) begin
                in_lit = 1'b1;
                col    = '0;
            end
            idx = (int'(col) >= ROW_B) ? ROW_B - 1 : int'(col);
            row_mem[ring_next * ROW_B + idx]    = b;
            row_mem_ok[ring_next * ROW_B + idx] = 1'b1;
            if (init_next < SLOTS) begin
                row_mem[init_next * ROW_B + idx]    = b;
                row_mem_ok[init_next * ROW_B + idx] = 1'b1;
            end
            last = (int'(col) + 1 >= nb);
            g.white_bits  = cfg_white ? b : ~b;
            g.pixel_count = last ? tail : PIX_FULL;
            g.row_end     = last;
            g.frame_end   = last & fe;
            g.run_last    = 1'b1;
            pending_groups.push_back(g);
            if (last) begin
                slot_filled[ring_next] = 1'b1;
                if (init_next < SLOTS) begin
                    slot_filled[init_next] = 1'b1;
                    init_next = init_next + 5'd1;
                end
                ring_next = (ring_next == 3'(BLACK - 1)) ? 3'd0 : ring_next + 3'd1;
                in_lit    = 1'b0;
                col       = '0;
                close_row(fe);
            end else begin
                col = col + 7'd1;
            end
        end
    endtask

    function automatic logic [7:0] literal_start();
        logic [7:0] b;
        int i;
        b = 8'($urandom);
        for (i = 0; i < 256 && is_escape(b); i++) b = b + 8'd1;
        return b;
    endfunction

    // escape aimed at a filled slot where the mask leaves the slot bits free
    function automatic logic [7:0] escape_byte();
        logic [7:0] b;
        int slot, i;
        slot = $urandom_range(0, SLOTS - 1);
        for (i = 0; i < SLOTS && !slot_filled[(slot + i) % SLOTS]; i++) ;
        if (i < SLOTS) slot = (slot + i) % SLOTS;
        b = (cfg_value & cfg_mask) | (8'($urandom) & ~cfg_mask);
        b[3:0] = (b[3:0] & cfg_mask[3:0]) | (4'(slot) & ~cfg_mask[3:0]);
        return b;
    endfunction

    task automatic send_byte(input logic [7:0] want);
        logic [7:0] b;
        int gap, i;
        b = want;
        for (i = 0; i < 256 && !replay_defined(b); i++) b = b + 8'd1;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
        decode_byte(b);
    endtask

    // wait for every expected word, then let the pipeline go quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_groups.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] a, input logic [CFG_DATA_W-1:0] d);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= a;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (a)
            REG_ROW_WIDTH:    cfg_width = d;
            REG_ROW_TOTAL:    cfg_total = d;
            REG_ESC_MASK:     cfg_mask  = d[7:0];
            REG_ESC_VALUE:    cfg_value = d[7:0];
            REG_COMPRESS_ON:  cfg_comp  = d[0];
            REG_ONE_IS_WHITE: cfg_white = d[0];
            default: ;
        endcase
    endtask

    function automatic t_script_row byte_step(input logic [7:0] b);
        t_script_row r;
        r       = '0;
        r.kind  = STEP_BYTE;
        r.value = {2'b00, b};
        return r;
    endfunction

    // single-group rows whose word is plain from the register settings
    function automatic t_script_row byte_step_exp(input logic [7:0] b, input logic [7:0] bits,
                                                  input logic fe);
        t_script_row r;
        r       = byte_step(b);
        r.typed = 1'b1;
        r.grp   = {bits, PIX_FULL, 1'b1, fe, 1'b1};
        return r;
    endfunction

    function automatic t_script_row reg_step(input logic [CFG_ADDR_W-1:0] a,
                                             input logic [CFG_DATA_W-1:0] d);
        t_script_row r;
        r       = '0;
        r.kind  = STEP_REG;
        r.addr  = a;
        r.value = d;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : check_out
        t_pixel_group want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_groups.size() == 0) begin
                $display("%0t: unexpected word, expected none, got tdata %h tlast %b",
                         $time, m_axis_tdata, m_axis_tlast);
                err_cnt++;
            end else begin
                want = pending_groups.pop_front();
                check_field("white_bits", want.white_bits, m_axis_tdata[7:0]);
                check_field("pixel_count", want.pixel_count, m_axis_tdata[11:8]);
                check_field("row_end", want.row_end, m_axis_tdata[12]);
                check_field("frame_end", want.frame_end, m_axis_tdata[13]);
                check_field("pad", 0, m_axis_tdata[15:14]);
                check_field("run_last", want.run_last, m_axis_tlast);
            end
        end
    end

    // sink: one long hold-off on request, otherwise a rotating stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done     <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            pace <= pace + 8'd1;
            case (pace[7:6])
                2'd0:    m_axis_tready <= 1'b1;
                2'd1:    m_axis_tready <= 1'($urandom_range(0, 1));
                2'd2:    m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int i, p, sent, budget;
        logic wide;
        logic [7:0] b, mask;

        // reset defaults, then frames of four rows
        script.push_back(byte_step_exp(8'h00, 8'h00, 1'b1));
        script.push_back(byte_step_exp(8'hFF, 8'h00, 1'b1));  // escape to a slot never filled
        script.push_back(byte_step_exp(8'hF8, 8'h00, 1'b1));  // escape to the black slot
        script.push_back(reg_step(REG_ROW_TOTAL, 10'd4));
        script.push_back(byte_step_exp(8'hA5, 8'hA5, 1'b0));
        script.push_back(byte_step_exp(8'hF0, 8'hA5, 1'b0));  // replay of the ring slot
        script.push_back(byte_step(8'hF9));                   // replay of an initial slot
        script.push_back(byte_step(8'h5A));
        script.push_back(reg_step(REG_ONE_IS_WHITE, 10'd0));
        script.push_back(byte_step(8'h0F));
        script.push_back(byte_step(8'hF0));                   // polarity applied on replay
        script.push_back(reg_step(REG_ONE_IS_WHITE, 10'd1));
        script.push_back(reg_step(REG_COMPRESS_ON, 10'd0));
        script.push_back(byte_step(8'hF1));
        script.push_back(reg_step(REG_COMPRESS_ON, 10'd1));
        script.push_back(reg_step(REG_ROW_WIDTH, 10'd12));
        script.push_back(byte_step(8'h12));
        script.push_back(byte_step(8'h34));
        script.push_back(byte_step(8'hF8));
        // width drops while a literal row is half done
        script.push_back(reg_step(REG_ROW_WIDTH, 10'd16));
        script.push_back(byte_step(8'hC3));
        script.push_back(reg_step(REG_ROW_WIDTH, 10'd8));
        script.push_back(byte_step(8'h3C));
        script.push_back(reg_step(REG_ESC_MASK, 10'h0FF));
        script.push_back(reg_step(REG_ESC_VALUE, 10'h000));
        script.push_back(byte_step(8'h00));
        script.push_back(byte_step(8'hF0));
        // zero width and zero total act as one
        script.push_back(reg_step(REG_ROW_WIDTH, 10'd0));
        script.push_back(reg_step(REG_ROW_TOTAL, 10'd0));
        script.push_back(byte_step(8'h80));
        script.push_back(byte_step(8'h7F));
        // oversized width saturates: a full 64-group replay
        script.push_back(reg_step(REG_ROW_WIDTH, 10'h3FF));
        script.push_back(byte_step(8'h00));
        script.push_back(reg_step(REG_SPARE_A, 10'h3FF));
        script.push_back(reg_step(REG_SPARE_B, 10'h000));
        script.push_back(byte_step(8'h00));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < script.size(); i++) begin
            if (script[i].kind == STEP_REG) begin
                write_reg(script[i].addr, script[i].value);
            end else begin
                send_byte(script[i].value[7:0]);
                if (script[i].typed) begin
                    void'(pending_groups.pop_back());
                    pending_groups.push_back(script[i].grp);
                end
            end
        end

        for (p = 0; p < PHASES; p++) begin
            wide = (p == 2);
            if (wide)
                write_reg(REG_ROW_WIDTH, $urandom_range(0, 1) ? 10'd512
                                                              : 10'($urandom_range(513, 1023)));
            else if ($urandom_range(0, 4) == 0)
                write_reg(REG_ROW_WIDTH, 10'($urandom_range(0, 64)));
            else
                write_reg(REG_ROW_WIDTH, 10'($urandom_range(1, 24)));
            case ($urandom_range(0, 5))
                0:       write_reg(REG_ROW_TOTAL, 10'd1);
                1:       write_reg(REG_ROW_TOTAL, 10'd0);
                2:       write_reg(REG_ROW_TOTAL, 10'd512);
                3:       write_reg(REG_ROW_TOTAL, 10'h3FF);
                default: write_reg(REG_ROW_TOTAL, 10'($urandom_range(2, 6)));
            endcase
            case (p % 4)
                0:       mask = 8'hF0;
                1:       mask = 8'hFF;
                3:       mask = (p == 3) ? 8'h00 : 8'($urandom);
                default: mask = 8'($urandom);
            endcase
            write_reg(REG_ESC_MASK, {2'b00, mask});
            if (p == 5)
                write_reg(REG_ESC_VALUE, 10'h0FF);
            else if ($urandom_range(0, 4) == 0)
                write_reg(REG_ESC_VALUE, 10'($urandom_range(0, 255)));
            else
                write_reg(REG_ESC_VALUE, {2'b00, mask & 8'($urandom)});
            write_reg(REG_COMPRESS_ON, ($urandom_range(0, 5) != 0) ? 10'd1 : 10'd0);
            write_reg(REG_ONE_IS_WHITE, 10'($urandom_range(0, 1)));
            if (p == 1) hold_req <= 1'b1;

            budget = wide ? 70 : 10;
            sent   = 0;
            // a phase may stop mid row; the next width then cuts or stretches it
            while (sent < budget) begin
                if (in_lit) begin
                    b = 8'($urandom);
                end else begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: b = literal_start();
                        5, 6, 7:       b = escape_byte();
                        default:       b = 8'($urandom);
                    endcase
                end
                send_byte(b);
                sent++;
            end
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0 && pending_groups.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/bmrr_pkg.sv
rtl/bmrr_ram.sv
rtl/bmrr_fifo.sv
rtl/bmrr_front.sv
rtl/bmrr_back.sv
rtl/bitmap_row_repeat_decoder.sv
tb/sv/tb_bitmap_row_repeat_decoder.sv
